FILE: design/mpe_pkg.sv
// Shared types, constants and helpers for the Mandelbrot pixel engine.
// No dependencies; every other design file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package mpe_pkg;

    // Field and datapath widths fixed by the pixel and Q4.28 formats.
    localparam int COORD_W   = 10;
    localparam int Q_W       = 32;
    localparam int STEP_W    = 31;
    localparam int OFS_W     = 13;
    localparam int PROD_W    = 45;
    localparam int WIDE_W    = 64;
    localparam int COLOR_W   = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 32;
    localparam int QUEUE_D   = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_REAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_IMAG = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_STEP  = 2'd2;

    // Reset value of the pixel step (4/800 in Q4.28).
    localparam logic [STEP_W-1:0] STEP_RESET = 31'd1342177;

    // Saturation limits of Q4.28 and the escape radius squared (4.0 in Q8.56).
    localparam logic signed [WIDE_W-1:0] Q_MAX = 64'sd2147483647;
    localparam logic signed [WIDE_W-1:0] Q_MIN = -64'sd2147483648;
    localparam logic [WIDE_W-1:0] ESC_BOUND    = 64'h0400_0000_0000_0000;

    // One mapped complex point, passed from the front end to the iterator.
    typedef struct packed {
        logic signed [Q_W-1:0] cx;
        logic signed [Q_W-1:0] cy;
    } t_point;

    // View settings held in the configuration registers.
    typedef struct packed {
        logic signed [Q_W-1:0] center_real;
        logic signed [Q_W-1:0] center_imag;
        logic [STEP_W-1:0]     pixel_step;
    } t_view;

    // Clamp a wide signed value to the Q4.28 range.
    function automatic logic signed [Q_W-1:0] sat_q(input logic signed [WIDE_W-1:0] v);
        logic signed [Q_W-1:0] r;
        if (v > Q_MAX) begin
            r = Q_MAX[Q_W-1:0];
        end else if (v < Q_MIN) begin
            r = Q_MIN[Q_W-1:0];
        end else begin
            r = v[Q_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: design/mpe_front.sv
// Front end: accepts pixel positions and maps them to complex points.
// Depends on mpe_pkg; feeds mpe_queue.
`timescale 1ns / 1ps
`default_nettype none

module mpe_front #(
    parameter int IMG_WIDTH  = 800,
    parameter int IMG_HEIGHT = 600
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_push,
    output logic                               o_full,
    input  wire logic [mpe_pkg::COORD_W-1:0]   i_column,
    input  wire logic [mpe_pkg::COORD_W-1:0]   i_image_row,
    input  wire mpe_pkg::t_view                i_view,
    input  wire logic                          i_q_full,
    output logic                               o_q_wr,
    output mpe_pkg::t_point                    o_point
);
    import mpe_pkg::*;

    localparam int HALF_W = IMG_WIDTH / 2;
    localparam int HALF_H = IMG_HEIGHT / 2;

    logic                     r_valid;
    logic                     n_valid;
    logic signed [PROD_W-1:0] r_prod_re;
    logic signed [PROD_W-1:0] r_prod_im;
    logic signed [OFS_W-1:0]  ofs_col;
    logic signed [OFS_W-1:0]  ofs_row;
    logic signed [PROD_W-1:0] ofs_col_ext;
    logic signed [PROD_W-1:0] ofs_row_ext;
    logic signed [PROD_W-1:0] step_ext;
    logic                     accept;

    // Offsets from the image center and their products with the step.
    assign ofs_col = $signed({{(OFS_W-COORD_W){1'b0}}, i_column}) - $signed(OFS_W'(HALF_W));
    assign ofs_row = $signed({{(OFS_W-COORD_W){1'b0}}, i_image_row})
                   - $signed(OFS_W'(HALF_H));
    assign ofs_col_ext = PROD_W'(ofs_col);
    assign ofs_row_ext = PROD_W'(ofs_row);
    assign step_ext    = $signed({{(PROD_W-STEP_W){1'b0}}, i_view.pixel_step});

    // The product stage holds one request until the queue takes it.
    assign o_full  = r_valid && i_q_full;
    assign accept  = i_push && !o_full;
    assign o_q_wr  = r_valid && !i_q_full;
    assign n_valid = accept || (r_valid && i_q_full);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_prod_re <= ofs_col_ext * step_ext;
            r_prod_im <= ofs_row_ext * step_ext;
        end
    end

    // Add the view center and clamp to Q4.28.
    always_comb begin
        o_point.cx = sat_q(WIDE_W'(i_view.center_real) + WIDE_W'(r_prod_re));
        o_point.cy = sat_q(WIDE_W'(i_view.center_imag) + WIDE_W'(r_prod_im));
    end

endmodule

`default_nettype wire

FILE: design/mpe_queue.sv
// Short queue of mapped points between the front end and the iterator.
// Depends on mpe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mpe_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_wr,
    input  wire mpe_pkg::t_point i_wr_data,
    output logic                 o_full,
    input  wire logic            i_rd,
    output mpe_pkg::t_point      o_rd_data,
    output logic                 o_empty
);
    import mpe_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_D);
    localparam int CNT_W = $clog2(QUEUE_D + 1);

    t_point             r_mem [QUEUE_D];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic               do_wr;
    logic               do_rd;

    assign o_full    = (r_count == CNT_W'(QUEUE_D));
    assign o_empty   = (r_count == '0);
    assign do_wr     = i_wr && !o_full;
    assign do_rd     = i_rd && !o_empty;
    assign o_rd_data = r_mem[r_rd_ptr];

    // Pointer and fill-count bookkeeping.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_wr) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_D - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_rd) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_D - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_wr && !do_rd) begin
                r_count <= r_count + 1'b1;
            end else if (do_rd && !do_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Storage write.
    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

endmodule

`default_nettype wire

FILE: design/mpe_back.sv
// Back end: escape-time iteration, colour mapping and the result register.
// Depends on mpe_pkg; reads points from mpe_queue.
`timescale 1ns / 1ps
`default_nettype none

module mpe_back #(
    parameter int ITER_LIMIT = 200
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_q_empty,
    input  wire mpe_pkg::t_point              i_q_point,
    output logic                              o_q_rd,
    input  wire logic                         i_out_pop,
    output logic                              o_out_valid,
    output logic [mpe_pkg::COLOR_W-1:0]       o_red,
    output logic [mpe_pkg::COLOR_W-1:0]       o_green,
    output logic [mpe_pkg::COLOR_W-1:0]       o_blue,
    output logic [mpe_pkg::COLOR_W-1:0]       o_iter_count,
    output logic                              o_inside_set
);
    import mpe_pkg::*;

    localparam int NW     = $clog2(ITER_LIMIT + 1);
    localparam int NXW    = NW + COLOR_W;
    localparam int RW     = $clog2(2 * ITER_LIMIT);
    localparam int RED_Q  = 255 / ITER_LIMIT;
    localparam int RED_R  = 255 % ITER_LIMIT;
    localparam int BLUE_Q = 128 / ITER_LIMIT;
    localparam int BLUE_R = 128 % ITER_LIMIT;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_UPD  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]               r_state;
    logic [1:0]               n_state;
    logic signed [Q_W-1:0]    r_cx;
    logic signed [Q_W-1:0]    r_cy;
    logic signed [Q_W-1:0]    r_x;
    logic signed [Q_W-1:0]    r_y;
    logic signed [WIDE_W-1:0] r_xx;
    logic signed [WIDE_W-1:0] r_yy;
    logic signed [WIDE_W-1:0] r_xy;
    logic [NW-1:0]            r_n;
    logic [COLOR_W-1:0]       r_red_q;
    logic [RW-1:0]            r_red_rem;
    logic [COLOR_W-1:0]       r_blue_q;
    logic [RW-1:0]            r_blue_rem;
    logic                     r_inside;
    logic                     r_out_valid;
    logic                     n_out_valid;
    logic [COLOR_W-1:0]       r_out_red;
    logic [COLOR_W-1:0]       r_out_green;
    logic [COLOR_W-1:0]       r_out_blue;
    logic [COLOR_W-1:0]       r_out_iter;
    logic                     r_out_inside;

    logic signed [WIDE_W-1:0] xx_c;
    logic signed [WIDE_W-1:0] yy_c;
    logic signed [WIDE_W-1:0] xy_c;
    logic [WIDE_W-1:0]        mag_sq;
    logic                     escape;
    logic                     last_iter;
    logic signed [WIDE_W-1:0] diff;
    logic signed [Q_W-1:0]    nx;
    logic signed [Q_W-1:0]    ny;
    logic [RW-1:0]            red_sum;
    logic [RW-1:0]            blue_sum;
    logic                     red_wrap;
    logic                     blue_wrap;
    logic                     out_free;
    logic [NXW-1:0]           n_wide;
    logic [COLOR_W-1:0]       green_c;

    // Products of the current orbit point.
    assign xx_c = r_x * r_x;
    assign yy_c = r_y * r_y;
    assign xy_c = r_x * r_y;

    // Escape test and the next orbit point from the registered products.
    assign mag_sq    = r_xx + r_yy;
    assign escape    = mag_sq > ESC_BOUND;
    assign last_iter = (r_n == NW'(ITER_LIMIT - 1));
    assign diff      = r_xx - r_yy;
    assign nx        = sat_q((diff >>> 28) + WIDE_W'(r_cx));
    assign ny        = sat_q((r_xy >>> 27) + WIDE_W'(r_cy));

    // Running quotient and remainder of n*255/LIMIT and n*128/LIMIT.
    assign red_sum   = r_red_rem + RW'(RED_R);
    assign blue_sum  = r_blue_rem + RW'(BLUE_R);
    assign red_wrap  = red_sum >= RW'(ITER_LIMIT);
    assign blue_wrap = blue_sum >= RW'(ITER_LIMIT);

    // Result formatting; green is 255 minus the rounded-up red fraction.
    assign n_wide  = NXW'(r_n);
    assign green_c = 8'd255 - r_red_q - COLOR_W'(r_red_rem != '0);

    assign o_q_rd   = (r_state == ST_IDLE) && !i_q_empty;
    assign out_free = !r_out_valid || i_out_pop;

    // Iteration sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (!i_q_empty) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                n_state = ST_UPD;
            end
            ST_UPD: begin
                if (escape || last_iter) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_MUL;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (i_out_pop) begin
            n_out_valid = 1'b0;
        end
        if ((r_state == ST_DONE) && out_free) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Orbit datapath and colour accumulators.
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (!i_q_empty) begin
                    r_cx       <= i_q_point.cx;
                    r_cy       <= i_q_point.cy;
                    r_x        <= '0;
                    r_y        <= '0;
                    r_n        <= '0;
                    r_red_q    <= '0;
                    r_red_rem  <= '0;
                    r_blue_q   <= '0;
                    r_blue_rem <= '0;
                    r_inside   <= 1'b0;
                end
            end
            ST_MUL: begin
                r_xx <= xx_c;
                r_yy <= yy_c;
                r_xy <= xy_c;
            end
            ST_UPD: begin
                if (!escape) begin
                    r_x      <= nx;
                    r_y      <= ny;
                    r_n      <= r_n + 1'b1;
                    r_inside <= last_iter;
                    if (red_wrap) begin
                        r_red_q   <= r_red_q + COLOR_W'(RED_Q + 1);
                        r_red_rem <= red_sum - RW'(ITER_LIMIT);
                    end else begin
                        r_red_q   <= r_red_q + COLOR_W'(RED_Q);
                        r_red_rem <= red_sum;
                    end
                    if (blue_wrap) begin
                        r_blue_q   <= r_blue_q + COLOR_W'(BLUE_Q + 1);
                        r_blue_rem <= blue_sum - RW'(ITER_LIMIT);
                    end else begin
                        r_blue_q   <= r_blue_q + COLOR_W'(BLUE_Q);
                        r_blue_rem <= blue_sum;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Result register, loaded when the previous result has been taken.
    always_ff @(posedge i_clk) begin
        if ((r_state == ST_DONE) && out_free) begin
            r_out_red    <= r_inside ? '0 : r_red_q;
            r_out_green  <= r_inside ? '0 : green_c;
            r_out_blue   <= r_inside ? '0 : r_blue_q;
            r_out_iter   <= (n_wide > NXW'(255)) ? 8'hFF : n_wide[COLOR_W-1:0];
            r_out_inside <= r_inside;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_red        = r_out_red;
    assign o_green      = r_out_green;
    assign o_blue       = r_out_blue;
    assign o_iter_count = r_out_iter;
    assign o_inside_set = r_out_inside;

endmodule

`default_nettype wire

FILE: design/mandelbrot_pixel_engine_core.sv
// Top level of the Mandelbrot pixel engine: configuration registers and wiring.
// Depends on mpe_pkg, mpe_front, mpe_queue and mpe_back.
//
// Usage: write center_real (index 0), center_imag (index 1) and pixel_step
// (index 2) on the configuration channel, which is always ready, while the
// engine is idle. Push pixel positions (column, image_row) while full is low.
// Each request gets one result: colour, iteration count and inside flag, shown
// while empty is low and removed by pop.
// Path: the mapping multiply is registered at the accepting edge; the point
// then passes the point queue, a setup step, each escape-time iteration (a
// products state, then a test-and-update state) and the result load.
// The single iteration unit works on one point at a time and takes the next
// from the queue only after loading the last result. The front end maps and
// queues up to three further pixels meanwhile.
// Reset clears the queue, the sequencer and the result valid flag and loads
// the configuration reset values. A stalled receiver holds the result
// register; the iterator then waits with its finished result and the front
// end fills up until full rises.
`timescale 1ns / 1ps
`default_nettype none

module mandelbrot_pixel_engine_core #(
    parameter int IMG_WIDTH  = 800,
    parameter int IMG_HEIGHT = 600,
    parameter int ITER_LIMIT = 200
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [mpe_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [mpe_pkg::CFG_DAT_W-1:0]   i_cfg_data,
    input  wire logic                            push,
    output logic                                 full,
    input  wire logic [mpe_pkg::COORD_W-1:0]     i_column,
    input  wire logic [mpe_pkg::COORD_W-1:0]     i_image_row,
    output logic                                 empty,
    input  wire logic                            pop,
    output logic [mpe_pkg::COLOR_W-1:0]          o_red,
    output logic [mpe_pkg::COLOR_W-1:0]          o_green,
    output logic [mpe_pkg::COLOR_W-1:0]          o_blue,
    output logic [mpe_pkg::COLOR_W-1:0]          o_iter_count,
    output logic                                 o_inside_set
);
    import mpe_pkg::*;

    t_view  r_view;
    logic   cfg_wr;
    logic   q_full;
    logic   q_wr;
    t_point q_wr_data;
    logic   q_rd;
    t_point q_rd_data;
    logic   q_empty;
    logic   out_valid;
    logic   out_pop;

    // Configuration registers.
    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_view.center_real <= '0;
            r_view.center_imag <= '0;
            r_view.pixel_step  <= STEP_RESET;
        end else if (cfg_wr) begin
            unique case (i_cfg_index)
                CFG_CENTER_REAL: r_view.center_real <= i_cfg_data;
                CFG_CENTER_IMAG: r_view.center_imag <= i_cfg_data;
                CFG_PIXEL_STEP:  r_view.pixel_step  <= i_cfg_data[STEP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Pixel mapping front end.
    mpe_front #(
        .IMG_WIDTH  (IMG_WIDTH),
        .IMG_HEIGHT (IMG_HEIGHT)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_column    (i_column),
        .i_image_row (i_image_row),
        .i_view      (r_view),
        .i_q_full    (q_full),
        .o_q_wr      (q_wr),
        .o_point     (q_wr_data)
    );

    // Point queue between the two halves.
    mpe_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (q_wr),
        .i_wr_data (q_wr_data),
        .o_full    (q_full),
        .i_rd      (q_rd),
        .o_rd_data (q_rd_data),
        .o_empty   (q_empty)
    );

    // Iteration back end with the result register.
    assign out_pop = pop && out_valid;
    assign empty   = !out_valid;

    mpe_back #(
        .ITER_LIMIT (ITER_LIMIT)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_empty    (q_empty),
        .i_q_point    (q_rd_data),
        .o_q_rd       (q_rd),
        .i_out_pop    (out_pop),
        .o_out_valid  (out_valid),
        .o_red        (o_red),
        .o_green      (o_green),
        .o_blue       (o_blue),
        .o_iter_count (o_iter_count),
        .o_inside_set (o_inside_set)
    );

endmodule

`default_nettype wire

FILE: design/mpe_checker.sv
// Port-level checks for the Mandelbrot pixel engine, bound to the top level.
// Depends on mpe_pkg and mandelbrot_pixel_engine_core.
`timescale 1ns / 1ps
`default_nettype none

module mpe_checker #(
    parameter int ITER_LIMIT = 200
) (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          full,
    input wire logic                          empty,
    input wire logic                          pop,
    input wire logic [mpe_pkg::COLOR_W-1:0]   o_red,
    input wire logic [mpe_pkg::COLOR_W-1:0]   o_green,
    input wire logic [mpe_pkg::COLOR_W-1:0]   o_blue,
    input wire logic [mpe_pkg::COLOR_W-1:0]   o_iter_count,
    input wire logic                          o_inside_set
);
    import mpe_pkg::*;

    localparam int LIMIT_SAT = (ITER_LIMIT > 255) ? 255 : ITER_LIMIT;

    // Reset leaves no result waiting and room for a request.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("engine not idle after reset");

    // A result that is not taken stays in place.
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_red) && $stable(o_green)
                              && $stable(o_blue) && $stable(o_iter_count)
                              && $stable(o_inside_set)))
        else $error("waiting result changed before pop");

    // Points inside the set are black and ran to the iteration limit.
    a_inside_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_inside_set) |-> (o_red == '0 && o_green == '0 && o_blue == '0
                                      && o_iter_count == COLOR_W'(LIMIT_SAT)))
        else $error("inside point with colour or short count");

    // For escaped points, red and green split the full scale.
    a_red_green: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_inside_set) |->
            ((9'(o_red) + 9'(o_green) == 9'd255) || (9'(o_red) + 9'(o_green) == 9'd254)))
        else $error("red and green out of balance");

endmodule

bind mandelbrot_pixel_engine_core mpe_checker #(
    .ITER_LIMIT (ITER_LIMIT)
) u_mpe_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .full         (full),
    .empty        (empty),
    .pop          (pop),
    .o_red        (o_red),
    .o_green      (o_green),
    .o_blue       (o_blue),
    .o_iter_count (o_iter_count),
    .o_inside_set (o_inside_set)
);

`default_nettype wire

FILE: bench/tb.sv
// Testbench for mandelbrot_pixel_engine_core: pixel requests are checked against an
// in-bench escape-time predictor, across several views and handshake idling patterns.
// Depends on mpe_pkg and the engine design files.
`timescale 1ns / 1ps

module tb;

    localparam int IMG_W       = 800;
    localparam int IMG_H       = 600;
    localparam int ITER_MAX    = 200;
    localparam int STALL_LIMIT = 5000;
    localparam int TAIL_CYCLES = 2 * ITER_MAX + 10;
    localparam int PRINT_LIMIT = 100;
    localparam int BATCH_ITEMS = 130;

    // Index 3 decodes to no register; writes there must change nothing.
    localparam logic [mpe_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    localparam longint Q_HI = 64'sd2147483647;
    localparam longint Q_LO = -64'sd2147483648;
    localparam logic [63:0] ESCAPE_SQ = 64'd1 << 58;

    // One expected result together with the request that caused it.
    typedef struct {
        logic [9:0] col;
        logic [9:0] row;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] iters;
        logic       in_set;
    } t_pixel_color;

    logic                              i_clk       = 1'b0;
    logic                              i_rst_n     = 1'b0;
    logic                              i_cfg_valid = 1'b0;
    logic                              o_cfg_ready;
    logic [mpe_pkg::CFG_IDX_W-1:0]     i_cfg_index = '0;
    logic [mpe_pkg::CFG_DAT_W-1:0]     i_cfg_data  = '0;
    logic                              push        = 1'b0;
    logic                              full;
    logic [mpe_pkg::COORD_W-1:0]       i_column    = '0;
    logic [mpe_pkg::COORD_W-1:0]       i_image_row = '0;
    logic                              empty;
    logic                              pop         = 1'b0;
    logic [mpe_pkg::COLOR_W-1:0]       o_red;
    logic [mpe_pkg::COLOR_W-1:0]       o_green;
    logic [mpe_pkg::COLOR_W-1:0]       o_blue;
    logic [mpe_pkg::COLOR_W-1:0]       o_iter_count;
    logic                              o_inside_set;

    // View registers as the predictor sees them.
    longint      view_real;
    longint      view_imag;
    logic [30:0] view_step;

    t_pixel_color pending_pixels[$];
    t_pixel_color oldest;
    int           mismatch_count = 0;
    int           send_idle_pct  = 0;
    int           pop_stall_pct  = 0;
    int           idle_cycles    = 0;

    mandelbrot_pixel_engine_core #(
        .IMG_WIDTH  (IMG_W),
        .IMG_HEIGHT (IMG_H),
        .ITER_LIMIT (ITER_MAX)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .push         (push),
        .full         (full),
        .i_column     (i_column),
        .i_image_row  (i_image_row),
        .empty        (empty),
        .pop          (pop),
        .o_red        (o_red),
        .o_green      (o_green),
        .o_blue       (o_blue),
        .o_iter_count (o_iter_count),
        .o_inside_set (o_inside_set)
    );

    // Free-running clock.
    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Clamp a wide value to the Q4.28 range.
    function automatic longint clamp_q(input longint v);
        if (v > Q_HI) begin
            return Q_HI;
        end
        if (v < Q_LO) begin
            return Q_LO;
        end
        return v;
    endfunction

    // Map a pixel to its complex point, run the escape-time loop and color the result.
    function automatic t_pixel_color escape_color(input logic [9:0] col, input logic [9:0] row);
        t_pixel_color r;
        longint       cx;
        longint       cy;
        longint       zx;
        longint       zy;
        longint       zx2;
        longint       zy2;
        longint       nx;
        logic [63:0]  mag;
        int           n;
        bit           escaped;
        cx = clamp_q(view_real + (longint'(col) - IMG_W / 2) * longint'(view_step));
        cy = clamp_q(view_imag + (longint'(row) - IMG_H / 2) * longint'(view_step));
        zx = 0;
        zy = 0;
        n = 0;
        escaped = 1'b0;
        while (n < ITER_MAX && !escaped) begin
            zx2 = zx * zx;
            zy2 = zy * zy;
            // The sum of squares is taken as an unsigned Q8.56 value.
            mag = zx2 + zy2;
            if (mag > ESCAPE_SQ) begin
                escaped = 1'b1;
            end else begin
                nx = clamp_q(((zx2 - zy2) >>> 28) + cx);
                zy = clamp_q(((zx * zy) >>> 27) + cy);
                zx = nx;
                n++;
            end
        end
        r.col = col;
        r.row = row;
        r.in_set = (n >= ITER_MAX);
        r.iters = (n > 255) ? 8'd255 : 8'(n);
        if (r.in_set) begin
            r.red = 8'd0;
            r.green = 8'd0;
            r.blue = 8'd0;
        end else begin
            r.red = 8'(n * 255 / ITER_MAX);
            r.green = 8'((ITER_MAX - n) * 255 / ITER_MAX);
            r.blue = 8'(n * 128 / ITER_MAX);
        end
        return r;
    endfunction

    // Count a mismatch and print a bounded number of them.
    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT) begin
            $display("%0t ERROR: %s", $time, msg);
        end
    endtask

    // Write one view register and mirror it in the predictor.
    task automatic write_view_reg(input logic [mpe_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [31:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            mpe_pkg::CFG_CENTER_REAL: view_real = longint'($signed(data));
            mpe_pkg::CFG_CENTER_IMAG: view_imag = longint'($signed(data));
            mpe_pkg::CFG_PIXEL_STEP:  view_step = data[30:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_view(input logic [31:0] re, input logic [31:0] im,
                            input logic [31:0] step);
        write_view_reg(mpe_pkg::CFG_CENTER_REAL, re);
        write_view_reg(mpe_pkg::CFG_CENTER_IMAG, im);
        write_view_reg(mpe_pkg::CFG_PIXEL_STEP, step);
    endtask

    // Send one pixel request; push stays high on return so back-to-back requests
    // follow without a gap.
    task automatic send_pixel(input logic [9:0] col, input logic [9:0] row);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            i_column <= 10'($urandom);
            i_image_row <= 10'($urandom);
            @(negedge i_clk);
        end
        push <= 1'b1;
        i_column <= col;
        i_image_row <= row;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        pending_pixels.push_back(escape_color(col, row));
    endtask

    // Stop requesting and wait until every expected result has been taken.
    task automatic drain_results();
        @(negedge i_clk);
        push <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
    endtask

    // Default view: center, corners, out-of-range positions and a few interior points.
    task automatic test_reset_view();
        send_pixel(10'd400, 10'd300);
        send_pixel(10'd0, 10'd0);
        send_pixel(10'd799, 10'd599);
        send_pixel(10'd1023, 10'd1023);
        send_pixel(10'd0, 10'd1023);
        send_pixel(10'd1023, 10'd0);
        send_pixel(10'd300, 10'd300);
        send_pixel(10'd200, 10'd300);
        send_pixel(10'd500, 10'd150);
        send_pixel(10'd350, 10'd400);
        drain_results();
    endtask

    // Register extremes: saturating centers, the largest and smallest steps and a zero step.
    task automatic test_view_extremes();
        set_view(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        send_pixel(10'd0, 10'd0);
        send_pixel(10'd799, 10'd599);
        send_pixel(10'd1023, 10'd1023);
        drain_results();
        set_view(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001);
        send_pixel(10'd0, 10'd599);
        send_pixel(10'd400, 10'd300);
        send_pixel(10'd1023, 10'd0);
        drain_results();
        // Bit 31 of the step write is dropped, so this gives a zero step at -1.0.
        set_view(32'hF000_0000, 32'h0000_0000, 32'h8000_0000);
        write_view_reg(CFG_SPARE, $urandom);
        send_pixel(10'd0, 10'd0);
        send_pixel(10'd1023, 10'd1023);
        drain_results();
    endtask

    // View: default if asked, else mostly near the set at moderate zoom, or else any value.
    task automatic pick_view(input bit use_default);
        int re;
        int im;
        int step;
        if (use_default) begin
            set_view(32'd0, 32'd0, 32'(mpe_pkg::STEP_RESET));
        end else if ($urandom_range(7) == 0) begin
            set_view($urandom, $urandom, $urandom);
        end else begin
            re = -536870912 + int'($urandom_range(671088640));
            im = -268435456 + int'($urandom_range(536870912));
            step = int'($urandom_range(1342177 * 2, 1342177 / 32));
            set_view(re, im, step);
        end
    endtask

    // Random pixels under each idling pattern, in a default and a random view.
    task automatic test_random_traffic();
        int idle_pct[4];
        int stall_pct[4];
        logic [9:0] col;
        logic [9:0] row;
        idle_pct = '{0, 74, 0, 16};
        stall_pct = '{0, 0, 74, 16};
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = idle_pct[ph];
            pop_stall_pct = stall_pct[ph];
            for (int v = 0; v < 2; v++) begin
                pick_view(v == 0);
                for (int k = 0; k < BATCH_ITEMS; k++) begin
                    // A tenth of the requests use the whole field range.
                    if ($urandom_range(9) == 0) begin
                        col = 10'($urandom);
                        row = 10'($urandom);
                    end else begin
                        col = 10'($urandom_range(IMG_W - 1));
                        row = 10'($urandom_range(IMG_H - 1));
                    end
                    send_pixel(col, row);
                end
                drain_results();
            end
        end
    endtask

    // Receiver side: pop at random, outside reset.
    always @(negedge i_clk) begin
        pop <= i_rst_n && ($urandom_range(99) >= pop_stall_pct);
    end

    // Compare each accepted result with the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            if (pending_pixels.size() == 0) begin
                report_mismatch($sformatf("unexpected result n=%0d inside=%0d",
                                          o_iter_count, o_inside_set));
            end else begin
                oldest = pending_pixels.pop_front();
                if (o_red !== oldest.red || o_green !== oldest.green ||
                    o_blue !== oldest.blue || o_iter_count !== oldest.iters ||
                    o_inside_set !== oldest.in_set) begin
                    report_mismatch({
                        $sformatf("pixel (%0d,%0d) want rgb %0d/%0d/%0d n=%0d in=%0d",
                                  oldest.col, oldest.row, oldest.red, oldest.green,
                                  oldest.blue, oldest.iters, oldest.in_set),
                        $sformatf(", got %0d/%0d/%0d n=%0d in=%0d",
                                  o_red, o_green, o_blue, o_iter_count, o_inside_set)});
                end
            end
        end
    end

    // Watchdog: end the run when no handshake completes for too long.
    initial begin
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((push && !full) || (pop && !empty) || (i_cfg_valid && o_cfg_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("Timeout: no handshake for %0d cycles", STALL_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    // Test sequence.
    initial begin
        view_real = 0;
        view_imag = 0;
        view_step = mpe_pkg::STEP_RESET;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_view();
        test_view_extremes();
        test_random_traffic();
        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

FILE: mandelbrot_pixel_engine_core.f
design/mpe_pkg.sv
design/mpe_front.sv
design/mpe_queue.sv
design/mpe_back.sv
design/mandelbrot_pixel_engine_core.sv
design/mpe_checker.sv
bench/tb.sv
